/* hw/rtl/line_rasterizer_top_assert.svh */
// Assertion macros shared by the line rasterizer RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LINE_RASTERIZER_TOP_ASSERT_SVH
`define LINE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LRZ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer assertion failed");

// Next-cycle implication.
`define LRZ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer assertion failed");

`endif

/* hw/rtl/lrz_pkg.sv */
`default_nettype none

package lrz_pkg;

    // Internal coordinate width; endpoint fields wrap to this width.
    localparam int COORD_BITS  = 16;
    localparam int FIELD_BITS  = 16;
    localparam int SCREEN_BITS = 13;
    localparam int CMP_BITS    = (COORD_BITS > SCREEN_BITS ? COORD_BITS : SCREEN_BITS) + 1;

    typedef logic signed [FIELD_BITS-1:0] field_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   diff_t;
    typedef logic [COORD_BITS-1:0]        span_t;
    typedef logic [COORD_BITS:0]          span2_t;
    typedef logic [COORD_BITS+1:0]        acc_t;
    typedef logic [SCREEN_BITS-1:0]       screen_t;
    typedef logic [CMP_BITS-1:0]          cmp_t;
    typedef logic [0:0]                   cfg_index_t;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } func_t;

    localparam cfg_index_t CFG_SCREEN_WIDTH  = 1'b0;
    localparam cfg_index_t CFG_SCREEN_HEIGHT = 1'b1;

    localparam screen_t SCREEN_WIDTH_RESET  = screen_t'(640);
    localparam screen_t SCREEN_HEIGHT_RESET = screen_t'(320);

    // Line parameters derived from a pair of endpoints.
    typedef struct packed {
        logic   major_is_y;
        coord_t major_start;
        coord_t minor_start;
        span_t  span;
        span_t  minor_mag;
        logic   minor_neg;
    } line_setup_t;

    // One rasterized pixel with its flags.
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   in_bounds;
        logic   all_in_bounds;
        logic   last;
    } pixel_t;

    function automatic coord_t coord_in(field_t v);
        return coord_t'(v);
    endfunction

    function automatic field_t coord_out(coord_t v);
        return field_t'(v);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/line_rasterizer_top.sv */
`default_nettype none

// Line rasterizer. A load transaction (func = 0) takes two endpoints, picks
// the major axis (y when |dy| > |dx|, otherwise x), orders the endpoints so
// the major coordinate rises, and produces no pixel. Each following step
// transaction (func = 1) produces one pixel, from the first endpoint to the
// second inclusive; the minor coordinate is the rounded ideal position,
// tracked with an error accumulator. Each pixel carries an in-bounds flag
// against screen_width and screen_height, a running AND of that flag over
// the line, and a mark on the last pixel. Steps with no line loaded, and
// loads, produce nothing. The block takes one transaction per clock while
// the pixel output is not stalled; the error update for a pixel is one add,
// one compare and one subtract on the walker's accumulator register. A
// step's pixel passes through the input register and then the pixel output
// register before it is presented. A stalled pixel output only holds back
// steps; loads pass through. Write the screen registers only while the
// block is idle.
module line_rasterizer_top
    import lrz_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,

    input  wire          cfg_write,
    input  wire [0:0]    cfg_index,
    input  wire screen_t cfg_data,

    input  wire          item_valid,
    output logic         item_stall,
    input  wire          func,
    input  wire field_t  start_x,
    input  wire field_t  start_y,
    input  wire field_t  end_x,
    input  wire field_t  end_y,

    output logic         pixel_valid,
    input  wire          pixel_stall,
    output field_t       pixel_x,
    output field_t       pixel_y,
    output logic         in_bounds,
    output logic         all_in_bounds,
    output logic         last_pixel
);

    // Screen size registers.
    screen_t screen_width_reg;
    screen_t screen_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register. It holds one transaction until the walker consumes it.
    logic   in_valid_reg;
    func_t  func_reg;
    coord_t x0_reg;
    coord_t y0_reg;
    coord_t x1_reg;
    coord_t y1_reg;

    logic        walk_active;
    pixel_t      walk_pix;
    line_setup_t setup;
    logic        is_step;
    logic        produces;
    logic        out_free;
    logic        advance;

    assign is_step  = func_reg == FUNC_STEP;
    // Only a step on an active line yields a pixel and needs the output free.
    assign produces = is_step && walk_active;
    assign out_free = !pixel_valid || !pixel_stall;
    assign advance  = in_valid_reg && (!produces || out_free);

    assign item_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            func_reg <= func_t'(func);
            x0_reg   <= coord_in(start_x);
            y0_reg   <= coord_in(start_y);
            x1_reg   <= coord_in(end_x);
            y1_reg   <= coord_in(end_y);
        end
    end

    lrz_line_setup u_setup
    (
        .x0    (x0_reg),
        .y0    (y0_reg),
        .x1    (x1_reg),
        .y1    (y1_reg),
        .setup (setup)
    );

    lrz_walker u_walker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && !is_step),
        .step          (advance && is_step),
        .setup         (setup),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .active        (walk_active),
        .pixel         (walk_pix)
    );

    // Pixel output register.
    logic   out_valid_reg;
    pixel_t out_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produces)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!pixel_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produces)
        begin
            out_pix_reg <= walk_pix;
        end
    end

    assign pixel_valid   = out_valid_reg;
    assign pixel_x       = coord_out(out_pix_reg.x);
    assign pixel_y       = coord_out(out_pix_reg.y);
    assign in_bounds     = out_pix_reg.in_bounds;
    assign all_in_bounds = out_pix_reg.all_in_bounds;
    assign last_pixel    = out_pix_reg.last;

`include "line_rasterizer_top_assert.svh"

    // A held pixel must never be overwritten by a new one.
    `LRZ_ASSERT_IMP(a_no_overwrite, pixel_valid && pixel_stall && produces, !advance)
    // The line ends once its last pixel has been produced.
    `LRZ_ASSERT_NXT(a_last_ends_line, advance && produces && walk_pix.last, !walk_active)
    // The running flag can only be set when this pixel itself is in bounds.
    `LRZ_ASSERT_IMP(a_all_implies_one, pixel_valid && all_in_bounds, in_bounds)
    // Backpressure on the input only appears with a transaction held.
    `LRZ_ASSERT_IMP(a_stall_needs_item, item_stall, in_valid_reg && produces)

endmodule

`default_nettype wire

/* hw/rtl/lrz_line_setup.sv */
`default_nettype none

module lrz_line_setup
    import lrz_pkg::*;
(
    input  wire coord_t      x0,
    input  wire coord_t      y0,
    input  wire coord_t      x1,
    input  wire coord_t      y1,
    output line_setup_t      setup
);

    diff_t dx;
    diff_t dy;
    span_t adx;
    span_t ady;
    diff_t dmaj;
    diff_t dmin;
    logic  major_is_y;
    logic  swap;

    assign dx = diff_t'(x1) - diff_t'(x0);
    assign dy = diff_t'(y1) - diff_t'(y0);

    assign adx = dx[COORD_BITS] ? span_t'(-dx) : span_t'(dx);
    assign ady = dy[COORD_BITS] ? span_t'(-dy) : span_t'(dy);

    // Ties go to x as the major axis.
    assign major_is_y = ady > adx;
    assign dmaj = major_is_y ? dy : dx;
    assign dmin = major_is_y ? dx : dy;

    // Walk from the endpoint with the smaller major coordinate.
    assign swap = dmaj[COORD_BITS];

    always_comb
    begin
        setup.major_is_y = major_is_y;
        if (major_is_y)
        begin
            setup.major_start = swap ? y1 : y0;
            setup.minor_start = swap ? x1 : x0;
            setup.span        = ady;
            setup.minor_mag   = adx;
        end
        else
        begin
            setup.major_start = swap ? x1 : x0;
            setup.minor_start = swap ? y1 : y0;
            setup.span        = adx;
            setup.minor_mag   = ady;
        end
        // Swapping the endpoints reverses the direction of the minor walk.
        setup.minor_neg = (dmin != '0) && (dmin[COORD_BITS] ^ swap);
    end

endmodule

`default_nettype wire

/* hw/rtl/lrz_walker.sv */
`default_nettype none

module lrz_walker
    import lrz_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              load,
    input  wire              step,
    input  wire line_setup_t setup,
    input  wire screen_t     screen_width,
    input  wire screen_t     screen_height,
    output logic             active,
    output pixel_t           pixel
);

    logic   major_is_y_reg;
    coord_t major_pos_reg;
    coord_t minor_pos_reg;
    span2_t span2_reg;
    span2_t mag2_reg;
    logic   minor_neg_reg;
    span_t  steps_left_reg;
    acc_t   error_acc_reg;
    logic   ok_so_far_reg;
    logic   active_reg;

    coord_t px;
    coord_t py;
    logic   in_bounds;
    logic   last;
    logic   all_ok;
    acc_t   acc_sum;
    logic   acc_wrap;

    assign px = major_is_y_reg ? minor_pos_reg : major_pos_reg;
    assign py = major_is_y_reg ? major_pos_reg : minor_pos_reg;

    assign in_bounds = !px[COORD_BITS-1] && !py[COORD_BITS-1]
        && (cmp_t'($unsigned(px)) < cmp_t'(screen_width))
        && (cmp_t'($unsigned(py)) < cmp_t'(screen_height));

    assign last   = steps_left_reg == '0;
    assign all_ok = ok_so_far_reg && in_bounds;

    // The sum stays below four spans, so one conditional subtract restores
    // the accumulator to the range below twice the span.
    assign acc_sum  = error_acc_reg + acc_t'(mag2_reg);
    assign acc_wrap = acc_sum >= acc_t'(span2_reg);

    assign active              = active_reg;
    assign pixel.x             = px;
    assign pixel.y             = py;
    assign pixel.in_bounds     = in_bounds;
    assign pixel.all_in_bounds = all_ok;
    assign pixel.last          = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_is_y_reg <= 1'b0;
            major_pos_reg  <= '0;
            minor_pos_reg  <= '0;
            span2_reg      <= '0;
            mag2_reg       <= '0;
            minor_neg_reg  <= 1'b0;
            steps_left_reg <= '0;
            error_acc_reg  <= '0;
            ok_so_far_reg  <= 1'b1;
            active_reg     <= 1'b0;
        end
        else if (load)
        begin
            major_is_y_reg <= setup.major_is_y;
            major_pos_reg  <= setup.major_start;
            minor_pos_reg  <= setup.minor_start;
            span2_reg      <= {setup.span, 1'b0};
            mag2_reg       <= {setup.minor_mag, 1'b0};
            minor_neg_reg  <= setup.minor_neg;
            steps_left_reg <= setup.span;
            error_acc_reg  <= acc_t'(setup.span);
            ok_so_far_reg  <= 1'b1;
            active_reg     <= 1'b1;
        end
        else if (step && active_reg)
        begin
            ok_so_far_reg <= all_ok;
            if (last)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                major_pos_reg  <= major_pos_reg + coord_t'(1);
                steps_left_reg <= steps_left_reg - span_t'(1);
                if (acc_wrap)
                begin
                    error_acc_reg <= acc_sum - acc_t'(span2_reg);
                    minor_pos_reg <= minor_neg_reg ? minor_pos_reg - coord_t'(1)
                                                   : minor_pos_reg + coord_t'(1);
                end
                else
                begin
                    error_acc_reg <= acc_sum;
                end
            end
        end
    end

endmodule

`default_nettype wire
